### rtl/bcd_pkg.sv
// Package of shared types, widths and codes for the boxcar decimator.
`default_nettype none
package bcd_pkg;
   localparam int RING_DEPTH = 4096;
   localparam int RING_AW    = $clog2(RING_DEPTH);

   localparam int FUNC_W   = 2;
   localparam int SAMPLE_W = 8;
   localparam int OFF_W    = 12;
   localparam int KIND_W   = 1;
   localparam int VALUE_W  = 8;
   localparam int DECIM_W  = 10;

   localparam int SUM_W  = 18;
   localparam int POS_W  = DECIM_W;
   localparam int NUM_W  = SUM_W + 2;
   localparam int DEN_W  = POS_W + 1;
   localparam int QUOT_W = VALUE_W;
   localparam int STEP_W = $clog2(QUOT_W);
   localparam int DSH_W  = DEN_W + QUOT_W - 1;

   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_AVG  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_HIST = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PUSH,
      ST_READ
   } state_type;
endpackage
`default_nettype wire

### rtl/bcd_if.sv
// Channel interfaces for requests, responses and the configuration write.
`default_nettype none
interface bcd_req_if;
   logic                            valid;
   logic                            ready;
   logic [bcd_pkg::FUNC_W-1:0]      func;
   logic [bcd_pkg::SAMPLE_W-1:0]    sample;
   logic [bcd_pkg::OFF_W-1:0]       back_offset;
   modport source (output valid, func, sample, back_offset, input ready);
   modport sink   (input valid, func, sample, back_offset, output ready);
endinterface

interface bcd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bcd_pkg::KIND_W-1:0]      kind;
   logic [bcd_pkg::VALUE_W-1:0]     value;
   modport source (output valid, kind, value, input ready);
   modport sink   (input valid, kind, value, output ready);
endinterface

interface bcd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bcd_pkg::DECIM_W-1:0]     decim_count;
   modport source (output valid, decim_count, input ready);
   modport sink   (input valid, decim_count, output ready);
endinterface
`default_nettype wire

### rtl/boxcar_decimator_with_history.sv
// Top level: boxcar averaging decimator with history ring and readback.
// A non-closing sample, a short flush or an unused code is done in the accepting cycle;
// a closing sample or an averaging flush runs accept, 8 restoring-divider steps, ring
// write and response. A history read runs accept with RAM read, then response.
// One request is in work at a time; a held response register stalls the last cycle.
// Reset (synchronous) clears sum, position, newest index and fill state and sets
// decim_count to 1; ring entries not yet written read as zero, no clearing pass.
`default_nettype none
module boxcar_decimator_with_history (
   input  wire logic  clock,
   input  wire logic  reset,
   bcd_req_if.sink    req_ch,
   bcd_rsp_if.source  rsp_ch,
   bcd_csr_if.sink    csr_ch
);
   bcd_pkg::state_type state_ff, state_in;

   logic [bcd_pkg::DECIM_W-1:0] decim_ff, decim_in;
   logic [bcd_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [bcd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [bcd_pkg::RING_AW-1:0] newest_ff, newest_in;
   logic                        full_ff, full_in;
   logic                        hit_ff, hit_in;
   logic [bcd_pkg::NUM_W-1:0]   rem_ff, rem_in;
   logic [bcd_pkg::DSH_W-1:0]   den_sh_ff, den_sh_in;
   logic [bcd_pkg::QUOT_W-1:0]  quot_ff, quot_in;
   logic [bcd_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bcd_pkg::KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [bcd_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic                        accept;
   logic                        out_free;
   logic [bcd_pkg::DECIM_W-1:0] n_eff;
   logic [bcd_pkg::SUM_W-1:0]   sum_new;
   logic [bcd_pkg::POS_W:0]     pos_new;
   logic [bcd_pkg::RING_AW-1:0] rd_idx;
   logic [bcd_pkg::RING_AW-1:0] push_idx;
   logic [bcd_pkg::NUM_W-1:0]   trial;
   logic                        ram_wr_en;
   logic                        ram_rd_en;
   logic [bcd_pkg::VALUE_W-1:0] ram_rd_data;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign n_eff    = (decim_ff == '0) ? bcd_pkg::DECIM_W'(1) : decim_ff;
   assign sum_new  = sum_ff + bcd_pkg::SUM_W'(req_ch.sample);
   assign pos_new  = {1'b0, pos_ff} + (bcd_pkg::POS_W + 1)'(1);
   assign rd_idx   = newest_ff - bcd_pkg::RING_AW'(req_ch.back_offset);
   assign push_idx = (newest_ff == bcd_pkg::RING_AW'(bcd_pkg::RING_DEPTH - 1)) ?
                     '0 : newest_ff + bcd_pkg::RING_AW'(1);
   assign trial    = rem_ff - bcd_pkg::NUM_W'(den_sh_ff);

   assign req_ch.ready = (state_ff == bcd_pkg::ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.kind  = rsp_kind_ff;
   assign rsp_ch.value = rsp_value_ff;

   always_comb begin
      state_in     = state_ff;
      decim_in     = decim_ff;
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      newest_in    = newest_ff;
      full_in      = full_ff;
      hit_in       = hit_ff;
      rem_in       = rem_ff;
      den_sh_in    = den_sh_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      if (csr_ch.valid && csr_ch.ready) begin
         decim_in = csr_ch.decim_count;
      end

      case (state_ff)
         bcd_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_ch.func)
                  bcd_pkg::FUNC_SAMPLE: begin
                     if (pos_new >= {1'b0, n_eff}) begin
                        rem_in    = bcd_pkg::NUM_W'({sum_new, 1'b0}) +
                                    bcd_pkg::NUM_W'(pos_new);
                        den_sh_in = {pos_new[bcd_pkg::POS_W-1:0], 1'b0,
                                     (bcd_pkg::QUOT_W - 1)'(0)};
                        quot_in   = '0;
                        step_in   = bcd_pkg::STEP_W'(bcd_pkg::QUOT_W - 1);
                        sum_in    = '0;
                        pos_in    = '0;
                        state_in  = bcd_pkg::ST_DIVIDE;
                     end else begin
                        sum_in = sum_new;
                        pos_in = pos_new[bcd_pkg::POS_W-1:0];
                     end
                  end
                  bcd_pkg::FUNC_FLUSH: begin
                     if (pos_ff > (n_eff >> 1)) begin
                        rem_in    = bcd_pkg::NUM_W'({sum_ff, 1'b0}) +
                                    bcd_pkg::NUM_W'(pos_ff);
                        den_sh_in = {pos_ff, 1'b0, (bcd_pkg::QUOT_W - 1)'(0)};
                        quot_in   = '0;
                        step_in   = bcd_pkg::STEP_W'(bcd_pkg::QUOT_W - 1);
                        state_in  = bcd_pkg::ST_DIVIDE;
                     end
                     sum_in = '0;
                     pos_in = '0;
                  end
                  bcd_pkg::FUNC_READ: begin
                     ram_rd_en = 1'b1;
                     hit_in    = full_ff || ((rd_idx != '0) && (rd_idx <= newest_ff));
                     state_in  = bcd_pkg::ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         bcd_pkg::ST_DIVIDE: begin
            if (rem_ff >= bcd_pkg::NUM_W'(den_sh_ff)) begin
               rem_in  = trial;
               quot_in = {quot_ff[bcd_pkg::QUOT_W-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[bcd_pkg::QUOT_W-2:0], 1'b0};
            end
            den_sh_in = den_sh_ff >> 1;
            step_in   = step_ff - bcd_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               state_in = bcd_pkg::ST_PUSH;
            end
         end
         bcd_pkg::ST_PUSH: begin
            if (out_free) begin
               ram_wr_en    = 1'b1;
               newest_in    = push_idx;
               full_in      = full_ff || (push_idx == '0);
               rsp_valid_in = 1'b1;
               rsp_kind_in  = bcd_pkg::KIND_AVG;
               rsp_value_in = quot_ff;
               state_in     = bcd_pkg::ST_IDLE;
            end
         end
         bcd_pkg::ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = bcd_pkg::KIND_HIST;
               rsp_value_in = hit_ff ? ram_rd_data : '0;
               state_in     = bcd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcd_pkg::ST_IDLE;
         decim_ff     <= bcd_pkg::DECIM_W'(1);
         sum_ff       <= '0;
         pos_ff       <= '0;
         newest_ff    <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         decim_ff     <= decim_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         newest_ff    <= newest_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff       <= hit_in;
      rem_ff       <= rem_in;
      den_sh_ff    <= den_sh_in;
      quot_ff      <= quot_in;
      step_ff      <= step_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
   end

   bcd_ram #(
      .WIDTH (bcd_pkg::VALUE_W),
      .DEPTH (bcd_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (push_idx),
      .wr_data (quot_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx),
      .rd_data (ram_rd_data)
   );
endmodule
`default_nettype wire

### rtl/bcd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### verif/boxcar_checker.sv
// Checker: watches the decimator channels, predicts each response and compares it field by field.
`timescale 1ns / 1ps
module boxcar_checker
   import bcd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bcd_req_if   req_ch,
   bcd_rsp_if   rsp_ch,
   bcd_csr_if   csr_ch,
   output int   fail_count,
   output int   pending,
   output int   request_count,
   output int   average_count,
   output int   read_count
);

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
   } bcd_result_type;

   bcd_result_type     predicted_outputs[$];
   logic [DECIM_W-1:0] block_length;
   logic [SUM_W-1:0]   block_sum;
   logic [POS_W-1:0]   block_pos;
   logic [VALUE_W-1:0] history[RING_DEPTH];
   logic [RING_AW-1:0] newest;
   int                 n_fail = 0;
   int                 n_req = 0;
   int                 n_avg = 0;
   int                 n_read = 0;

   function automatic logic [VALUE_W-1:0] rounded_mean(input int unsigned total,
                                                       input int unsigned held);
      int unsigned q;
      q = (2 * total + held) / (2 * held);
      return q[VALUE_W-1:0];
   endfunction

   // close the running block: store its mean in the ring and expect it out
   task automatic close_block();
      bcd_result_type res;
      res.kind  = KIND_AVG;
      res.value = rounded_mean(block_sum, block_pos);
      block_sum = '0;
      block_pos = '0;
      newest = newest + 1'b1;
      history[newest] = res.value;
      predicted_outputs.push_back(res);
      n_avg++;
   endtask

   task automatic advance_boxcar(input logic [FUNC_W-1:0]   func,
                                 input logic [SAMPLE_W-1:0] smp,
                                 input logic [OFF_W-1:0]    off);
      int unsigned        blk;
      bcd_result_type     res;
      logic [RING_AW-1:0] idx;
      blk = (block_length == '0) ? 1 : block_length;
      case (func)
         FUNC_SAMPLE: begin
            block_sum = block_sum + smp;
            block_pos = block_pos + 1'b1;
            if (block_pos >= blk)
               close_block();
         end
         FUNC_FLUSH: begin
            if (block_pos > blk / 2) begin
               close_block();
            end else begin
               block_sum = '0;
               block_pos = '0;
            end
         end
         FUNC_READ: begin
            idx = newest - off[RING_AW-1:0];
            res.kind  = KIND_HIST;
            res.value = history[idx];
            predicted_outputs.push_back(res);
            n_read++;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      bcd_result_type want;
      if (reset) begin
         predicted_outputs.delete();
         block_length = 1;
         block_sum = '0;
         block_pos = '0;
         newest = '0;
         for (int i = 0; i < RING_DEPTH; i++)
            history[i] = '0;
         n_fail = 0;
         n_req = 0;
         n_avg = 0;
         n_read = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("response with none expected: kind %0d value %0d",
                      rsp_ch.kind, rsp_ch.value);
               n_fail++;
            end else begin
               want = predicted_outputs.pop_front();
               if (rsp_ch.kind !== want.kind) begin
                  $error("kind mismatch: expected %0d, actual %0d", want.kind, rsp_ch.kind);
                  n_fail++;
               end
               if (rsp_ch.value !== want.value) begin
                  $error("value mismatch: expected %0d, actual %0d",
                         want.value, rsp_ch.value);
                  n_fail++;
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready)
            block_length = csr_ch.decim_count;
         if (req_ch.valid && req_ch.ready) begin
            n_req++;
            advance_boxcar(req_ch.func, req_ch.sample, req_ch.back_offset);
         end
      end
      fail_count    <= n_fail;
      pending       <= predicted_outputs.size();
      request_count <= n_req;
      average_count <= n_avg;
      read_count    <= n_read;
   end

endmodule

### verif/testbench.sv
// Testbench top: drives requests and block-length writes into the boxcar decimator.
`timescale 1ns / 1ps
module testbench;
   import bcd_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 16;
   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int MIX_ITEMS    = 7;

   logic clock;
   logic reset;
   logic rsp_hold;
   int   req_idle_pct;
   int   rsp_idle_pct;
   int   quiet_cycles = 0;
   int   settings_used = 0;
   int   fail_count;
   int   pending;
   int   request_count;
   int   average_count;
   int   read_count;

   bcd_req_if req_ch ();
   bcd_rsp_if rsp_ch ();
   bcd_csr_if csr_ch ();

   boxcar_decimator_with_history DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   boxcar_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending       (pending),
      .request_count (request_count),
      .average_count (average_count),
      .read_count    (read_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !reset && !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $error("no handshake for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_request(input logic [FUNC_W-1:0]   func,
                               input logic [SAMPLE_W-1:0] smp,
                               input logic [OFF_W-1:0]    off);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= func;
      req_ch.sample      <= smp;
      req_ch.back_offset <= off;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold until every response is out, then let the last request settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_block_length(input logic [DECIM_W-1:0] len);
      wait_drained();
      csr_ch.valid       <= 1'b1;
      csr_ch.decim_count <= len;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic send_mix(input int count);
      int                  pick;
      int                  level;
      logic [SAMPLE_W-1:0] smp;
      logic [OFF_W-1:0]    off;
      repeat (count) begin
         pick  = $urandom_range(99);
         level = $urandom_range(9);
         smp   = (level == 0) ? '0 : (level == 1) ? '1 : SAMPLE_W'($urandom());
         off   = ($urandom_range(3) == 0) ? OFF_W'($urandom()) : OFF_W'($urandom_range(15));
         if (pick < 70)
            send_request(FUNC_SAMPLE, smp, off);
         else if (pick < 82)
            send_request(FUNC_FLUSH, smp, off);
         else if (pick < 97)
            send_request(FUNC_READ, smp, off);
         else
            send_request(FUNC_UNUSED, smp, off);
      end
   endtask

   initial begin
      int lengths[7] = '{1, 2, 3, 4, 7, 0, 9};
      reset              = 1'b1;
      rsp_hold           = 1'b0;
      req_idle_pct       = 13;
      rsp_idle_pct       = 58;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_SAMPLE;
      req_ch.sample      = '0;
      req_ch.back_offset = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.decim_count = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(FUNC_READ, 8'd0, 12'd0);
      send_request(FUNC_READ, 8'd0, 12'hFFF);
      send_request(FUNC_SAMPLE, 8'h00, 12'd0);
      send_request(FUNC_SAMPLE, 8'hFF, 12'd0);
      send_request(FUNC_UNUSED, 8'hFF, 12'hFFF);
      send_request(FUNC_READ, 8'd0, 12'd0);
      send_request(FUNC_READ, 8'd0, 12'd1);
      send_request(FUNC_READ, 8'd0, 12'd4094);
      write_block_length(10'd0);
      send_request(FUNC_SAMPLE, 8'h80, 12'd0);
      write_block_length(10'd4);
      send_request(FUNC_SAMPLE, 8'd1, 12'd0);
      send_request(FUNC_SAMPLE, 8'd2, 12'd0);
      send_request(FUNC_FLUSH, 8'd0, 12'd0);
      send_request(FUNC_SAMPLE, 8'd10, 12'd0);
      send_request(FUNC_SAMPLE, 8'd20, 12'd0);
      send_request(FUNC_SAMPLE, 8'd30, 12'd0);
      send_request(FUNC_FLUSH, 8'd0, 12'd0);
      repeat (4) send_request(FUNC_SAMPLE, 8'hFF, 12'd0);
      send_request(FUNC_FLUSH, 8'd0, 12'd0);
      write_block_length(10'd8);
      send_request(FUNC_SAMPLE, 8'd100, 12'd0);
      send_request(FUNC_SAMPLE, 8'd101, 12'd0);
      send_request(FUNC_SAMPLE, 8'd102, 12'd0);
      write_block_length(10'd2);
      send_request(FUNC_SAMPLE, 8'd103, 12'd0);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct <= (phase == 0) ? 13 : (phase == 1) ? 58 : 0;
         rsp_idle_pct <= (phase == 0) ? 58 : (phase == 1) ? 13 : 0;
         lengths[6] = $urandom_range(5, 40);
         foreach (lengths[k]) begin
            write_block_length(DECIM_W'(lengths[k]));
            if (phase == 0 && k == 0)
               fork
                  begin
                     rsp_hold <= 1'b1;
                     repeat (HOLD_CYCLES) @(posedge clock);
                     rsp_hold <= 1'b0;
                  end
               join_none
            send_mix(MIX_ITEMS);
         end
      end

      write_block_length(10'd1023);
      repeat (520)
         send_request(FUNC_SAMPLE,
                      ($urandom_range(7) == 0) ? SAMPLE_W'($urandom()) : 8'hFF, 12'd0);
      send_request(FUNC_FLUSH, 8'd0, 12'd0);
      send_mix(20);
      wait_drained();

      $display("Covered %0d requests: %0d block averages and %0d history reads,",
               request_count, average_count, read_count);
      $display("over %0d block-length writes and three sender/receiver idling mixes.",
               settings_used);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (pending != 0)
            $error("%0d expected responses never arrived", pending);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### boxcar_decimator_with_history.f
rtl/bcd_pkg.sv
rtl/bcd_if.sv
rtl/bcd_ram.sv
rtl/boxcar_decimator_with_history.sv
verif/boxcar_checker.sv
verif/testbench.sv
